// ===== rtl/vec4alu_pkg.sv =====
// ============================================================================
// vec4alu_pkg: shared types and constants of the four-component vector ALU
// Operation codes, port packing offsets, lane and sideband structs, and the
// saturation helper used by the lanes and the merge logic.
// ============================================================================
package vec4alu_pkg;

    localparam int KIND_W      = 4;
    localparam int WORD_W      = 32;
    localparam int IN_TDATA_W  = 9 * WORD_W;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_EQ_BIT  = 5 * WORD_W;
    localparam int OUT_DZ_BIT  = 5 * WORD_W + 1;
    localparam int SQRT_STAGES = 32;
    localparam int ROOT_W      = 33;
    localparam int DEN_W       = 33;

    localparam logic [KIND_W-1:0] KIND_ADD   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SUB   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MUL   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DIV   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SCALE = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SDIV  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_NEG   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_DOT   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MAGSQ = 4'd8;
    localparam logic [KIND_W-1:0] KIND_MAG   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_NORM  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_EQ    = 4'd11;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Quotient sign and special-case flags of one lane
    typedef struct packed {
        logic a_neg;
        logic q_neg;
        logic a_zero;
        logic dsr_zero;
    } divflag_t;

    // Divider operands of one lane (magnitudes)
    typedef struct packed {
        logic [31:0] dvd;
        logic [31:0] dsr;
        divflag_t    flag;
    } divop_t;

    // First-stage result of one lane
    typedef struct packed {
        logic signed [63:0] prod;
        logic signed [31:0] simple;
        logic               same;
        divop_t             op;
    } lane_t;

    // Sideband carried alongside the square-root chain
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              eq;
        logic [3:0][31:0]  r_vec;
        logic [31:0]       rs;
        divop_t [3:0]      op;
    } side1_t;

    // Sideband carried alongside the divider chain
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              eq;
        logic [3:0][31:0]  r_vec;
        logic [31:0]       rs;
        divflag_t [3:0]    flag;
    } side2_t;

    // Clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat_wide(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return SAT_MAX;
        end else if (v < -66'sd2147483648) begin
            return SAT_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/vec4alu_lane.sv =====
// ============================================================================
// vec4alu_lane: per-component front end
// Registers the component product, the saturated add/sub/negate result and the
// divider operands of one vector component.
// ============================================================================
module vec4alu_lane (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [vec4alu_pkg::KIND_W-1:0]   kind,
    input  logic signed [31:0]               a,
    input  logic signed [31:0]               b,
    input  logic signed [31:0]               s,
    output vec4alu_pkg::lane_t               lane_q
);
    import vec4alu_pkg::*;

    logic signed [31:0] op2;
    logic signed [31:0] dsrc;
    logic signed [32:0] sum;
    logic signed [32:0] diff;
    logic signed [32:0] negv;
    lane_t              lane_next;
    lane_t              lane_reg;

    // Select multiplier and divisor operands, form the simple results
    always_comb begin
        if (kind inside {KIND_MUL, KIND_DOT}) begin
            op2 = b;
        end else if (kind == KIND_SCALE) begin
            op2 = s;
        end else begin
            op2 = a;
        end
        dsrc = (kind == KIND_SDIV) ? s : b;
        sum  = 33'(a) + 33'(b);
        diff = 33'(a) - 33'(b);
        negv = -33'(a);

        lane_next.prod = 64'(a) * 64'(op2);
        case (kind)
            KIND_ADD: lane_next.simple = sat_wide(66'(sum));
            KIND_SUB: lane_next.simple = sat_wide(66'(diff));
            KIND_NEG: lane_next.simple = sat_wide(66'(negv));
            default:  lane_next.simple = '0;
        endcase
        lane_next.same              = (a == b);
        lane_next.op.dvd            = a[31] ? -a : a;
        lane_next.op.dsr            = dsrc[31] ? -dsrc : dsrc;
        lane_next.op.flag.a_neg     = a[31];
        lane_next.op.flag.q_neg     = (kind == KIND_NORM) ? a[31] : (a[31] ^ dsrc[31]);
        lane_next.op.flag.a_zero    = (a == 32'sd0);
        lane_next.op.flag.dsr_zero  = (dsrc == 32'sd0);
    end

    // Advance with the pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_q = lane_reg;

endmodule

// ===== rtl/vec4alu_sqrt.sv =====
// ============================================================================
// vec4alu_sqrt: pipelined integer square root
// One result bit per stage over a 64-bit radicand; a radicand of 2^64 or more
// gives 2^32.
// ============================================================================
module vec4alu_sqrt (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [63:0]                     rad,
    input  logic                            big,
    output logic [vec4alu_pkg::ROOT_W-1:0]  root
);
    import vec4alu_pkg::*;

    localparam int REM_W = 35;

    logic [REM_W-1:0] rem_reg  [1:SQRT_STAGES];
    logic [31:0]      root_reg [1:SQRT_STAGES];
    logic [63:0]      rad_reg  [1:SQRT_STAGES];
    logic             big_reg  [1:SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [31:0]      root_in;
        logic [63:0]      rad_in;
        logic             big_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [31:0]      root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign big_in  = big;
        end else begin : g_rest
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign rad_in  = rad_reg[k];
            assign big_in  = big_reg[k];
        end

        // Bring in two radicand bits and try the next root bit
        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[63:62]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                rad_reg[k+1]  <= {rad_in[61:0], 2'b00};
                big_reg[k+1]  <= big_in;
            end
        end
    end

    assign root = big_reg[SQRT_STAGES] ? {1'b1, 32'h0}
                                       : {1'b0, root_reg[SQRT_STAGES]};

endmodule

// ===== rtl/vec4alu_div.sv =====
// ============================================================================
// vec4alu_div: pipelined restoring divider
// Unsigned quotient of an NUM_W-bit numerator by a 33-bit divisor, one
// quotient bit per stage.
// ============================================================================
module vec4alu_div #(
    parameter int NUM_W = 48
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [NUM_W-1:0]               num,
    input  logic [vec4alu_pkg::DEN_W-1:0]  den,
    output logic [NUM_W-1:0]               quo
);
    import vec4alu_pkg::*;

    logic [DEN_W-1:0] rem_reg [1:NUM_W];
    logic [NUM_W-1:0] nq_reg  [1:NUM_W];
    logic [DEN_W-1:0] den_reg [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   sh;
        logic [DEN_W:0]   dif;
        logic             qbit;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k];
            assign nq_in  = nq_reg[k];
            assign den_in = den_reg[k];
        end

        // Shift in the next numerator bit and subtract where it fits
        always_comb begin
            sh   = {rem_in, nq_in[NUM_W-1]};
            dif  = sh - {1'b0, den_in};
            qbit = (sh >= {1'b0, den_in});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= qbit ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
                nq_reg[k+1]  <= {nq_in[NUM_W-2:0], qbit};
                den_reg[k+1] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NUM_W];

endmodule

// ===== rtl/vec4alu_delay.sv =====
// ============================================================================
// vec4alu_delay: sideband delay line
// Carries a valid bit and a payload word through DEPTH stages in step with a
// datapath chain.
// ============================================================================
module vec4alu_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         valid_reg [DEPTH];
    logic [W-1:0] data_reg  [DEPTH];

    // Shift valid bits; clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Shift payload
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++) begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

// ===== rtl/four_component_vector_alu.sv =====
// ============================================================================
// four_component_vector_alu: Q-format four-component vector ALU
// Add, subtract, multiply, divide, scale, negate, dot, magnitude, normalize
// and compare on vector pairs, with saturation, one result per transfer.
//
//   channel | ports            | payload
//   --------+------------------+---------------------------------------------
//   input   | s_tvalid/tready  | tuser: kind; tdata: A, B, scalar
//   result  | m_tvalid/tready  | tdata: R vector, r_scalar, equal, div_zero
//
// One transfer accepted per cycle while the output buffer's second entry is
// free. Results pass the front stages, the 32-stage square-root chain and the
// per-lane divider chains that produce one quotient bit per stage.
// Reset clears the valid bits of the pipeline and the output buffer only.
// A two-entry output buffer decouples the sides; the pipeline holds while its
// second entry is occupied.
// ============================================================================
module four_component_vector_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar
    input  logic [vec4alu_pkg::IN_TDATA_W-1:0]    s_tdata,
    // kind
    input  logic [vec4alu_pkg::KIND_W-1:0]        s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // r_x, r_y, r_z, r_w, r_scalar, equal, div_zero, zero fill
    output logic [vec4alu_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import vec4alu_pkg::*;

    localparam int Q_W = WORD_W + FRAC_BITS;
    localparam int S1_W = $bits(side1_t);
    localparam int S2_W = $bits(side2_t);

    logic               en;
    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];
    logic signed [31:0] sc_in;

    lane_t              lane_t1 [4];
    logic               valid_t1_reg, valid_t2_reg, valid_t3_reg;
    logic [KIND_W-1:0]  kind_t1_reg, kind_t2_reg, kind_t3_reg;
    logic               eq_t2_reg, eq_t3_reg;
    logic [3:0][31:0]   rvec_t2_next;
    logic [3:0][31:0]   rvec_t2_reg, rvec_t3_reg;
    divop_t [3:0]       op_t2_reg, op_t3_reg;
    logic signed [64:0] s01_t2_reg, s23_t2_reg;
    logic signed [65:0] total_t3_reg;

    side1_t             s1_in, s1_out;
    logic [S1_W-1:0]    s1_out_bits;
    logic               valid_s1;
    logic [ROOT_W-1:0]  mag_root;

    side2_t             s2_in, s2_out;
    logic [S2_W-1:0]    s2_out_bits;
    logic               valid_s2;
    logic [Q_W-1:0]     quo [4];

    logic [3:0][31:0]   r_fin;
    logic               dz_fin;
    logic [OUT_TDATA_W-1:0] push_data;
    logic               push, pop;

    logic               m_valid_reg, m_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, skid_data_reg;
    logic               load_m, load_skid, m_from_skid;

    // Hold the whole pipeline while the skid entry is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Unpack the input transfer
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_in[i] = s_tdata[WORD_W*i +: WORD_W];
            b_in[i] = s_tdata[WORD_W*(4+i) +: WORD_W];
        end
        sc_in = s_tdata[WORD_W*8 +: WORD_W];
    end

    // Component lanes
    for (genvar i = 0; i < 4; i++) begin : g_lane
        vec4alu_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .kind   (s_tuser),
            .a      (a_in[i]),
            .b      (b_in[i]),
            .s      (sc_in),
            .lane_q (lane_t1[i])
        );
    end

    // Valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_t1_reg <= 1'b0;
            valid_t2_reg <= 1'b0;
            valid_t3_reg <= 1'b0;
        end else if (en) begin
            valid_t1_reg <= s_tvalid;
            valid_t2_reg <= valid_t1_reg;
            valid_t3_reg <= valid_t2_reg;
        end
    end

    // Pass add/sub/negate results; rescale products for mul and scale
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (kind_t1_reg inside {KIND_ADD, KIND_SUB, KIND_NEG}) begin
                rvec_t2_next[i] = lane_t1[i].simple;
            end else if (kind_t1_reg inside {KIND_MUL, KIND_SCALE}) begin
                rvec_t2_next[i] = sat_wide(66'(lane_t1[i].prod) >>> FRAC_BITS);
            end else begin
                rvec_t2_next[i] = '0;
            end
        end
    end

    // Front stages: kind, pairwise product sums, then the full sum
    always_ff @(posedge aclk) begin
        if (en) begin
            kind_t1_reg  <= s_tuser;
            kind_t2_reg  <= kind_t1_reg;
            eq_t2_reg    <= (kind_t1_reg == KIND_EQ) && lane_t1[0].same && lane_t1[1].same
                            && lane_t1[2].same && lane_t1[3].same;
            rvec_t2_reg  <= rvec_t2_next;
            s01_t2_reg   <= 65'(lane_t1[0].prod) + 65'(lane_t1[1].prod);
            s23_t2_reg   <= 65'(lane_t1[2].prod) + 65'(lane_t1[3].prod);
            for (int i = 0; i < 4; i++) begin
                op_t2_reg[i] <= lane_t1[i].op;
            end
            kind_t3_reg  <= kind_t2_reg;
            eq_t3_reg    <= eq_t2_reg;
            rvec_t3_reg  <= rvec_t2_reg;
            op_t3_reg    <= op_t2_reg;
            total_t3_reg <= 66'(s01_t2_reg) + 66'(s23_t2_reg);
        end
    end

    // Dot and squared magnitude form here; mag and normalize wait for the root
    always_comb begin
        s1_in.kind  = kind_t3_reg;
        s1_in.eq    = eq_t3_reg;
        s1_in.r_vec = rvec_t3_reg;
        s1_in.rs    = (kind_t3_reg inside {KIND_DOT, KIND_MAGSQ})
                      ? sat_wide(total_t3_reg >>> FRAC_BITS) : '0;
        s1_in.op    = op_t3_reg;
    end

    vec4alu_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (total_t3_reg[63:0]),
        .big  (total_t3_reg[64]),
        .root (mag_root)
    );

    vec4alu_delay #(.W(S1_W), .DEPTH(SQRT_STAGES)) u_delay_s1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_t3_reg),
        .in_data   (s1_in),
        .out_valid (valid_s1),
        .out_data  (s1_out_bits)
    );
    assign s1_out = side1_t'(s1_out_bits);

    // Magnitude result and sideband for the divider chain
    always_comb begin
        s2_in.kind  = s1_out.kind;
        s2_in.eq    = s1_out.eq;
        s2_in.r_vec = s1_out.r_vec;
        if (s1_out.kind == KIND_MAG) begin
            s2_in.rs = (mag_root > ROOT_W'(SAT_MAX)) ? SAT_MAX : mag_root[31:0];
        end else begin
            s2_in.rs = s1_out.rs;
        end
        for (int i = 0; i < 4; i++) begin
            s2_in.flag[i] = s1_out.op[i].flag;
        end
    end

    // Per-lane dividers: by the root for normalize, else by B or the scalar
    for (genvar i = 0; i < 4; i++) begin : g_div
        logic [DEN_W-1:0] den;
        assign den = (s1_out.kind == KIND_NORM) ? mag_root : {1'b0, s1_out.op[i].dsr};

        vec4alu_div #(.NUM_W(Q_W)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  ({s1_out.op[i].dvd, {FRAC_BITS{1'b0}}}),
            .den  (den),
            .quo  (quo[i])
        );
    end

    vec4alu_delay #(.W(S2_W), .DEPTH(Q_W)) u_delay_s2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_s1),
        .in_data   (s2_in),
        .out_valid (valid_s2),
        .out_data  (s2_out_bits)
    );
    assign s2_out = side2_t'(s2_out_bits);

    // Merge lane quotients, saturate, flag zero divisors
    always_comb begin
        logic [31:0] qval;
        logic        all_zero;
        dz_fin   = 1'b0;
        all_zero = s2_out.flag[0].a_zero && s2_out.flag[1].a_zero
                   && s2_out.flag[2].a_zero && s2_out.flag[3].a_zero;
        for (int i = 0; i < 4; i++) begin
            if (s2_out.flag[i].q_neg) begin
                qval = (quo[i] > Q_W'(32'h8000_0000)) ? SAT_MIN : -quo[i][31:0];
            end else begin
                qval = (quo[i] > Q_W'(32'h7fff_ffff)) ? SAT_MAX : quo[i][31:0];
            end
            if (s2_out.kind inside {KIND_DIV, KIND_SDIV}) begin
                if (s2_out.flag[i].dsr_zero) begin
                    dz_fin = 1'b1;
                    if (s2_out.flag[i].a_zero) begin
                        r_fin[i] = '0;
                    end else begin
                        r_fin[i] = s2_out.flag[i].a_neg ? SAT_MIN : SAT_MAX;
                    end
                end else begin
                    r_fin[i] = qval;
                end
            end else if (s2_out.kind == KIND_NORM) begin
                r_fin[i] = all_zero ? '0 : qval;
            end else begin
                r_fin[i] = s2_out.r_vec[i];
            end
        end
        push_data = {6'b0, dz_fin, s2_out.eq, s2_out.rs,
                     r_fin[3], r_fin[2], r_fin[1], r_fin[0]};
    end

    // Two-entry output buffer control
    assign push = en && valid_s2;
    assign pop  = m_valid_reg && m_tready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_m          = 1'b0;
        load_skid       = 1'b0;
        m_from_skid     = 1'b0;
        if (skid_valid_reg) begin
            if (pop) begin
                m_from_skid     = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                load_m       = 1'b1;
                m_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_m) begin
            m_data_reg <= push_data;
        end else if (m_from_skid) begin
            m_data_reg <= skid_data_reg;
        end
        if (load_skid) begin
            skid_data_reg <= push_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/vec4alu_checker.sv =====
// ============================================================================
// vec4alu_checker: port-level checks of the vector ALU
// Watches the stream ports for result hold, buffer backpressure and flag
// consistency.
// ============================================================================
module vec4alu_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [vec4alu_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import vec4alu_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input side stalls only behind a waiting result
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Input side drops ready only after a stalled result transfer
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("ready dropped without result backpressure");

    // Compare and divide flags come from different operations
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_EQ_BIT] && m_tdata[OUT_DZ_BIT]))
        else $error("equal and div_zero both set");

endmodule

bind four_component_vector_alu vec4alu_checker u_checker (.*);

// ===== test/four_component_vector_alu_tb.sv =====
// ============================================================================
// four_component_vector_alu_tb: self-checking bench of the vector ALU
// Drives a table of directed vector pairs and then random traffic with random
// idle cycles on both channels; each result transfer is checked against an
// in-bench Q16.16 predictor of every operation kind.
// ============================================================================
module four_component_vector_alu_tb;
    import vec4alu_pkg::*;

    localparam int FRAC       = 16;
    localparam int N_RANDOM   = 1430;
    localparam int LATENCY    = 3 + 32 + 32 + FRAC + 1;
    localparam int CYCLE_MAX  = 400000;
    localparam longint LMAX   = 64'sd2147483647;
    localparam longint LMIN   = -64'sd2147483648;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [31:0]       a [4];
        logic [31:0]       b [4];
        logic [31:0]       scal;
    } vec_op_t;

    typedef struct {
        logic [31:0] r [4];
        logic [31:0] rs;
        logic        eq;
        logic        dz;
    } vec_res_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    vec_res_t alu_expected_q [$];
    int  error_cnt = 0;
    longint cycle_cnt = 0;
    bit  quiet_phase;

    four_component_vector_alu #(.FRAC_BITS(FRAC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        if (v > LMAX) return LMAX;
        if (v < LMIN) return LMIN;
        return v;
    endfunction

    function automatic longint fix_mul(input longint x, input longint y);
        return clamp32((x * y) >>> FRAC);
    endfunction

    function automatic longint fix_div(input longint x, input longint y, inout bit dz);
        longint unsigned q;
        if (y == 0) begin
            dz = 1'b1;
            return (x > 0) ? LMAX : ((x < 0) ? LMIN : 0);
        end
        q = ((x < 0 ? -x : x) << FRAC) / (y < 0 ? -y : y);
        return ((x < 0) != (y < 0)) ? clamp32(-longint'(q)) : clamp32(longint'(q));
    endfunction

    // Exact dot product in 128 bits, floored
    function automatic longint fix_dot(input longint x [4], input longint y [4]);
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < 4; i++) acc += 128'(signed'(x[i])) * 128'(signed'(y[i]));
        acc = acc >>> FRAC;
        if (acc > 128'(LMAX)) return LMAX;
        if (acc < 128'(LMIN)) return LMIN;
        return longint'(acc);
    endfunction

    // Magnitude rounded down; 2^32 when the sum of squares overflows 64 bits
    function automatic longint unsigned vec_length(input longint x [4]);
        logic [65:0] sum;
        logic [65:0] res;
        logic [65:0] bitv;
        longint unsigned u;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            u = x[i] < 0 ? -x[i] : x[i];
            sum += 66'(u) * 66'(u);
        end
        if (sum[65:64] != 0) return 64'd1 << 32;
        res  = 0;
        bitv = 66'd1 << 62;
        while (bitv > sum) bitv >>= 2;
        while (bitv != 0) begin
            if (sum >= res + bitv) begin
                sum -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic vec_res_t alu_predict(input vec_op_t op);
        vec_res_t res;
        longint x [4];
        longint y [4];
        longint s;
        longint r [4];
        longint rs;
        longint unsigned m;
        longint unsigned q;
        bit dz;
        bit eq;
        for (int i = 0; i < 4; i++) begin
            x[i] = longint'(signed'(op.a[i]));
            y[i] = longint'(signed'(op.b[i]));
            r[i] = 0;
        end
        s  = longint'(signed'(op.scal));
        rs = 0;
        dz = 1'b0;
        eq = 1'b0;
        case (op.kind)
            KIND_ADD:   for (int i = 0; i < 4; i++) r[i] = clamp32(x[i] + y[i]);
            KIND_SUB:   for (int i = 0; i < 4; i++) r[i] = clamp32(x[i] - y[i]);
            KIND_MUL:   for (int i = 0; i < 4; i++) r[i] = fix_mul(x[i], y[i]);
            KIND_DIV:   for (int i = 0; i < 4; i++) r[i] = fix_div(x[i], y[i], dz);
            KIND_SCALE: for (int i = 0; i < 4; i++) r[i] = fix_mul(x[i], s);
            KIND_SDIV:  for (int i = 0; i < 4; i++) r[i] = fix_div(x[i], s, dz);
            KIND_NEG:   for (int i = 0; i < 4; i++) r[i] = clamp32(-x[i]);
            KIND_DOT:   rs = fix_dot(x, y);
            KIND_MAGSQ: rs = fix_dot(x, x);
            KIND_MAG: begin
                m  = vec_length(x);
                rs = (m > longint'(LMAX)) ? LMAX : longint'(m);
            end
            KIND_NORM: begin
                m = vec_length(x);
                if (m != 0) begin
                    for (int i = 0; i < 4; i++) begin
                        q = ((x[i] < 0 ? -x[i] : x[i]) << FRAC) / m;
                        r[i] = clamp32(x[i] < 0 ? -longint'(q) : longint'(q));
                    end
                end
            end
            KIND_EQ: eq = (x[0] == y[0]) && (x[1] == y[1]) && (x[2] == y[2]) && (x[3] == y[3]);
            default: ;
        endcase
        for (int i = 0; i < 4; i++) res.r[i] = r[i][31:0];
        res.rs = rs[31:0];
        res.eq = eq;
        res.dz = dz;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Random word biased toward extremes, small values and zero
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return 32'(signed'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_op_t make_op(input logic [KIND_W-1:0] k,
                                        input logic [31:0] a0, input logic [31:0] a1,
                                        input logic [31:0] a2, input logic [31:0] a3,
                                        input logic [31:0] b0, input logic [31:0] b1,
                                        input logic [31:0] b2, input logic [31:0] b3,
                                        input logic [31:0] sc);
        vec_op_t op;
        op.kind = k;
        op.a[0] = a0; op.a[1] = a1; op.a[2] = a2; op.a[3] = a3;
        op.b[0] = b0; op.b[1] = b1; op.b[2] = b2; op.b[3] = b3;
        op.scal = sc;
        return op;
    endfunction

    // Hold the transfer until accepted; idle first at random outside the quiet phase
    task automatic send_op(input vec_op_t op);
        if (!quiet_phase) begin
            while ($urandom_range(0, 99) < 25) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.kind;
        s_tdata  <= {op.scal, op.b[3], op.b[2], op.b[1], op.b[0],
                     op.a[3], op.a[2], op.a[1], op.a[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        alu_expected_q.push_back(alu_predict(op));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, compare each transfer with oldest entry
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        vec_res_t exp_r;
        vec_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            for (int i = 0; i < 4; i++) got.r[i] = m_tdata[32*i +: 32];
            got.rs = m_tdata[128 +: 32];
            got.eq = m_tdata[OUT_EQ_BIT];
            got.dz = m_tdata[OUT_DZ_BIT];
            if (alu_expected_q.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, m_tdata);
                error_cnt++;
            end else begin
                exp_r = alu_expected_q.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.r[i] !== exp_r.r[i]) begin
                        $display("%0t: r[%0d] expected %h actual %h",
                                 $time, i, exp_r.r[i], got.r[i]);
                        error_cnt++;
                    end
                end
                if (got.rs !== exp_r.rs) begin
                    $display("%0t: r_scalar expected %h actual %h", $time, exp_r.rs, got.rs);
                    error_cnt++;
                end
                if (got.eq !== exp_r.eq) begin
                    $display("%0t: equal expected %b actual %b", $time, exp_r.eq, got.eq);
                    error_cnt++;
                end
                if (got.dz !== exp_r.dz) begin
                    $display("%0t: div_zero expected %b actual %b", $time, exp_r.dz, got.dz);
                    error_cnt++;
                end
            end
        end
        m_tready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table and random traffic
    // ------------------------------------------------------------------------
    initial begin
        vec_op_t  dir_tbl [$];
        vec_op_t  op;
        vec_res_t fixed_r;
        int       wait_cnt;
        quiet_phase = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, every kind, zero divisors, zero normalize, unused kinds
        dir_tbl = '{
            make_op(KIND_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0,
                    32'h1, 32'h80000000, 32'hffffffff, 32'h0, 32'h0),
            make_op(KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h5, 32'h0,
                    32'h1, 32'hffffffff, 32'h5, 32'h0, 32'h0),
            make_op(KIND_MUL, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000,
                    32'h7fffffff, 32'h80000000, 32'h1, 32'h00020000, 32'h0),
            make_op(KIND_DIV, 32'h00010000, 32'hffff0000, 32'h0, 32'h80000000,
                    32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h0),
            make_op(KIND_DIV, 32'h00030000, 32'hfffd0000, 32'h7fffffff, 32'h1,
                    32'h00020000, 32'h00020000, 32'h1, 32'h7fffffff, 32'h0),
            make_op(KIND_SCALE, 32'h7fffffff, 32'h80000000, 32'h00018000, 32'hffffffff,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h00020000),
            make_op(KIND_SDIV, 32'h00010000, 32'hffff0000, 32'h0, 32'h7fffffff,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_SDIV, 32'h00010000, 32'hffff0000, 32'h80000000, 32'h7fffffff,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'hffff8000),
            make_op(KIND_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0),
            make_op(KIND_DOT, 32'h00010000, 32'h00020000, 32'hfffd0000, 32'h0,
                    32'h00010000, 32'h00010000, 32'h00010000, 32'h7fffffff, 32'h0),
            make_op(KIND_MAGSQ, 32'h00030000, 32'h00040000, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_MAG, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_MAG, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_NORM, 32'h0, 32'h0, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_NORM, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_NORM, 32'h1, 32'h0, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_NORM, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
            make_op(KIND_EQ, 32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                    32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 32'h0),
            make_op(KIND_EQ, 32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                    32'h80000000, 32'h7fffffff, 32'h0, 32'hfffffffe, 32'h0),
            make_op(4'd12, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff),
            make_op(4'd15, 32'h1, 32'h0, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0)
        };

        // Rows with results typed in: saturated add, zero-divisor sdiv, unused kind
        foreach (dir_tbl[i]) begin
            send_op(dir_tbl[i]);
            fixed_r = alu_expected_q[$];
            if (i == 0) begin
                fixed_r.r = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h0};
                fixed_r.rs = 0; fixed_r.eq = 0; fixed_r.dz = 0;
            end else if (i == 6) begin
                fixed_r.r = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff};
                fixed_r.rs = 0; fixed_r.eq = 0; fixed_r.dz = 1;
            end else if (i == 20) begin
                fixed_r.r = '{32'h0, 32'h0, 32'h0, 32'h0};
                fixed_r.rs = 0; fixed_r.eq = 0; fixed_r.dz = 0;
            end
            alu_expected_q[$] = fixed_r;
        end

        // Random traffic; a stretch in the middle runs with no idling
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_phase = (n >= 500) && (n < 700);
            op.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                   : 4'($urandom_range(0, 11));
            for (int i = 0; i < 4; i++) begin
                op.a[i] = pick_word();
                op.b[i] = ($urandom_range(0, 5) == 0) ? op.a[i] : pick_word();
            end
            op.scal = pick_word();
            send_op(op);
        end
        s_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        wait_cnt = 0;
        while (alu_expected_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (LATENCY + 20) @(posedge aclk);

        if (error_cnt == 0 && alu_expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
